[hdl/bspt_pkg.sv]
// Shared types, register codes and constants for the biphasic stimulus pulse timer.
package bspt_pkg;

    // Register indexes on the configuration write port.
    typedef enum logic [1:0] {
        CFG_PULSE_PERIOD   = 2'd0,
        CFG_PULSE_CURRENT  = 2'd1,
        CFG_PHASE_WIDTH    = 2'd2,
        CFG_INTERPHASE_GAP = 2'd3
    } cfg_addr_t;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register limits and reset values.
    localparam logic [15:0] PERIOD_MIN   = 16'd160;
    localparam logic [15:0] PERIOD_RESET = 16'd6554;
    localparam logic [7:0]  CURRENT_MAX  = 8'd200;
    localparam logic [7:0]  WIDTH_MIN    = 8'd1;
    localparam logic [7:0]  WIDTH_RESET  = 8'd57;
    localparam logic [7:0]  GAP_RESET    = 8'd6;

    // Low-frequency ticks per uptime second, as the exponent of a power of two.
    localparam int SECOND_DIVIDE_BITS_DEF = 15;

    // Widths of the stream payloads.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    // Pulse sequence phases.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_FWD  = 3'd1,
        PH_GAP  = 3'd2,
        PH_REV  = 3'd3
    } phase_t;

    // Electrode drive codes.
    typedef enum logic [1:0] {
        MODE_GND = 2'd0,
        MODE_FWD = 2'd1,
        MODE_REV = 2'd2
    } mode_t;

    // Live configuration register values.
    typedef struct packed {
        logic [15:0] pulse_period;
        logic [7:0]  pulse_current;
        logic [7:0]  phase_width;
        logic [7:0]  interphase_gap;
    } cfg_t;

    // Pulse part of one result.
    typedef struct packed {
        logic       pulse_busy;
        logic [7:0] dac_code;
        mode_t      electrode_mode;
    } pulse_out_t;

    // One result item, first field in the highest bits.
    typedef struct packed {
        logic [31:0] uptime_seconds;
        logic        pulse_busy;
        logic [7:0]  dac_code;
        logic [1:0]  electrode_mode;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

[hdl/biphasic_stim_pulse_timer.sv]
// Top level: biphasic stimulus pulse timer with stream input and output.
// A result is registered in the output register, or first in the skid stage when the output stalls.
// Throughput: one transaction per cycle while s_tready is high; the state update and result are combinational.
// A stalled output is absorbed by one skid stage; s_tready falls only when it is full.
// Reset (aresetn low, synchronous) idles the pulse, clears counters and empties the output,
// and loads the register reset values.
module biphasic_stim_pulse_timer
    import bspt_pkg::*;
#(
    parameter int SECOND_DIVIDE_BITS = SECOND_DIVIDE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // [0] lf_tick, [1] us_tick, rest zero
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // [1:0] electrode_mode, [9:2] dac_code,
                                            // [10] pulse_busy, [42:11] uptime_seconds
);

    cfg_t       cfg;
    pulse_out_t pulse_out;
    result_t    result;
    result_t    m_data;
    logic [31:0] uptime_seconds;
    logic       accept;
    logic       lf_tick;
    logic       us_tick;

    assign accept  = s_tvalid && s_tready;
    assign lf_tick = s_tdata[0];
    assign us_tick = s_tdata[1];

    bspt_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bspt_pulse_seq u_pulse_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (accept),
        .lf_tick   (lf_tick),
        .us_tick   (us_tick),
        .cfg       (cfg),
        .pulse_out (pulse_out)
    );

    bspt_uptime #(
        .SECOND_DIVIDE_BITS (SECOND_DIVIDE_BITS)
    ) u_uptime (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (accept),
        .lf_tick        (lf_tick),
        .uptime_seconds (uptime_seconds)
    );

    // Assemble the result of this transaction.
    always_comb begin
        result.electrode_mode = pulse_out.electrode_mode;
        result.dac_code       = pulse_out.dac_code;
        result.pulse_busy     = pulse_out.pulse_busy;
        result.uptime_seconds = uptime_seconds;
    end

    bspt_out_skid u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (result),
        .ready     (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (m_data)
    );

    assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, m_data};

endmodule

[hdl/bspt_cfg_regs.sv]
// Configuration registers with saturation on write.
module bspt_cfg_regs
    import bspt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [7:0] wdata_lo;

    assign wdata_lo = cfg_wdata[7:0];

    // Decode the write and clamp the value into the register's range.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_PULSE_PERIOD: begin
                    cfg_next.pulse_period = (cfg_wdata < PERIOD_MIN) ? PERIOD_MIN : cfg_wdata;
                end
                CFG_PULSE_CURRENT: begin
                    cfg_next.pulse_current = (wdata_lo > CURRENT_MAX) ? CURRENT_MAX : wdata_lo;
                end
                CFG_PHASE_WIDTH: begin
                    cfg_next.phase_width = (wdata_lo == 8'd0) ? WIDTH_MIN : wdata_lo;
                end
                CFG_INTERPHASE_GAP: begin
                    cfg_next.interphase_gap = wdata_lo;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // Register bank.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_period   <= PERIOD_RESET;
            cfg_reg.pulse_current  <= 8'd0;
            cfg_reg.phase_width    <= WIDTH_RESET;
            cfg_reg.interphase_gap <= GAP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // The stored period never falls below its minimum.
    a_period_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (cfg_reg.pulse_period >= PERIOD_MIN))
        else $error("pulse period below minimum");

    // The stored current never exceeds its maximum.
    a_current_ceiling: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (cfg_reg.pulse_current <= CURRENT_MAX))
        else $error("pulse current above maximum");

endmodule

[hdl/bspt_pulse_seq.sv]
// Period counter and biphasic pulse phase sequencer.
module bspt_pulse_seq
    import bspt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic       lf_tick,
    input  logic       us_tick,
    input  cfg_t       cfg,
    output pulse_out_t pulse_out
);

    phase_t      phase_reg;
    phase_t      phase_next;
    phase_t      phase_us;
    logic [7:0]  us_count_reg;
    logic [7:0]  us_count_next;
    logic [7:0]  us_count_us;
    logic [7:0]  us_count_inc;
    logic [15:0] period_count_reg;
    logic [15:0] period_count_next;
    logic [15:0] period_count_inc;
    logic [7:0]  dur;
    logic        in_pulse;
    logic        phase_done;

    assign us_count_inc     = us_count_reg + 8'd1;
    assign period_count_inc = period_count_reg + 16'd1;
    assign phase_done       = us_tick && in_pulse && (us_count_inc >= dur);

    // Phase state register and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            us_count_reg     <= 8'd0;
            period_count_reg <= 16'd0;
        end else begin
            phase_reg        <= phase_next;
            us_count_reg     <= us_count_next;
            period_count_reg <= period_count_next;
        end
    end

    // Duration of the running phase, read live from the registers.
    always_comb begin
        dur      = cfg.phase_width;
        in_pulse = 1'b1;
        unique case (phase_reg)
            PH_FWD, PH_REV: dur = cfg.phase_width;
            PH_GAP:         dur = cfg.interphase_gap;
            default:        in_pulse = 1'b0;
        endcase
    end

    // The running pulse advances on the microsecond tick first.
    always_comb begin
        phase_us    = phase_reg;
        us_count_us = us_count_reg;
        if (!in_pulse) begin
            // Idle, or an unused code that falls back to idle.
            phase_us    = PH_IDLE;
            us_count_us = 8'd0;
        end else if (us_tick) begin
            if (phase_done) begin
                us_count_us = 8'd0;
                unique case (phase_reg)
                    PH_FWD:  phase_us = (cfg.interphase_gap == 8'd0) ? PH_REV : PH_GAP;
                    PH_GAP:  phase_us = PH_REV;
                    default: phase_us = PH_IDLE;
                endcase
            end else begin
                us_count_us = us_count_inc;
            end
        end
    end

    // Then the period counter; a match starts a pulse only when idle.
    always_comb begin
        phase_next        = phase_reg;
        us_count_next     = us_count_reg;
        period_count_next = period_count_reg;
        if (step_en) begin
            phase_next    = phase_us;
            us_count_next = us_count_us;
            if (lf_tick) begin
                period_count_next = period_count_inc;
                if (period_count_inc >= cfg.pulse_period) begin
                    period_count_next = 16'd0;
                    if (phase_us == PH_IDLE) begin
                        phase_next    = PH_FWD;
                        us_count_next = 8'd0;
                    end
                end
            end
        end
    end

    // Electrode drive follows the phase after this transaction's update.
    always_comb begin
        pulse_out.electrode_mode = MODE_GND;
        pulse_out.dac_code       = 8'd0;
        pulse_out.pulse_busy     = (phase_us != PH_IDLE);
        if (lf_tick && (period_count_inc >= cfg.pulse_period) && (phase_us == PH_IDLE)) begin
            pulse_out.electrode_mode = MODE_FWD;
            pulse_out.dac_code       = cfg.pulse_current;
            pulse_out.pulse_busy     = 1'b1;
        end else begin
            unique case (phase_us)
                PH_FWD: begin
                    pulse_out.electrode_mode = MODE_FWD;
                    pulse_out.dac_code       = cfg.pulse_current;
                end
                PH_REV: begin
                    pulse_out.electrode_mode = MODE_REV;
                    pulse_out.dac_code       = cfg.pulse_current;
                end
                default: begin
                    pulse_out.electrode_mode = MODE_GND;
                end
            endcase
        end
    end

    // The microsecond count is zero whenever no pulse runs.
    a_idle_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (phase_reg == PH_IDLE) |-> (us_count_reg == 8'd0))
        else $error("us count not cleared while idle");

    // A pulse starts only on an accepted low-frequency tick.
    a_start_on_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (phase_reg == PH_FWD) && ($past(phase_reg) == PH_IDLE)
        |-> $past(step_en && lf_tick))
        else $error("pulse started without a low-frequency tick");

endmodule

[hdl/bspt_uptime.sv]
// Uptime seconds counter fed by a power-of-two tick divider.
module bspt_uptime
    import bspt_pkg::*;
#(
    parameter int SECOND_DIVIDE_BITS = SECOND_DIVIDE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic        lf_tick,
    output logic [31:0] uptime_seconds
);

    logic [SECOND_DIVIDE_BITS-1:0] divider_reg;
    logic [SECOND_DIVIDE_BITS-1:0] divider_next;
    logic [31:0]                   seconds_reg;
    logic [31:0]                   seconds_next;
    logic                          tick;
    logic                          wrap;

    assign tick = step_en && lf_tick;
    assign wrap = tick && (&divider_reg);

    always_comb begin
        divider_next = tick ? divider_reg + {{(SECOND_DIVIDE_BITS-1){1'b0}}, 1'b1}
                            : divider_reg;
        seconds_next = wrap ? seconds_reg + 32'd1 : seconds_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg <= '0;
            seconds_reg <= 32'd0;
        end else begin
            divider_reg <= divider_next;
            seconds_reg <= seconds_next;
        end
    end

    // The result carries the count after this transaction's update.
    assign uptime_seconds = seconds_next;

    // Seconds advance only when the divider rolls over.
    a_second_on_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (seconds_reg != $past(seconds_reg))
        |-> ($past(wrap) && (divider_reg == '0)))
        else $error("seconds advanced without divider rollover");

endmodule

[hdl/bspt_out_skid.sv]
// Output register with a skid stage for the result stream.
module bspt_out_skid
    import bspt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    ready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    assign pop   = out_valid_reg && m_tready;
    assign ready = !skid_valid_reg;

    // Refill the output register from the skid stage first, then from a new result.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_data_next  = push_data;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_data   = out_data_reg;

    // The skid stage holds data only behind a full output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage valid with empty output register");

    // A result pushed into a stalled full output goes to the skid stage.
    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        push && out_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("result lost on stalled output");

endmodule
